// File: rtl/mcct_pkg.sv
// Package with the shared constants, widths and stage records of the color temperature pipeline.
package mcct_pkg;

  localparam int ChW   = 16;
  localparam int TriW  = 36;
  localparam int SumW  = 38;
  localparam int QW    = 32;
  localparam int DivDw = 56;
  localparam int DivDv = 39;

  localparam logic signed [QW-1:0] XWhiteQ16 = 32'sd21758;
  localparam logic signed [QW-1:0] YEpiQ16   = 32'sd12177;
  localparam logic signed [QW-1:0] NMinQ16   = -32'sd1048576;
  localparam logic signed [QW-1:0] NMaxQ16   = 32'sd524288;
  localparam logic signed [QW-1:0] SatMax    = 32'sh7fffffff;
  localparam logic signed [QW-1:0] SatMin    = -32'sh7fffffff - 32'sd1;
  localparam logic signed [15:0]   PolyA3    = 16'sd449;
  localparam logic signed [15:0]   PolyA2    = 16'sd3525;
  localparam logic signed [QW-1:0] PolyA1    = 32'sd447171789;
  localparam logic signed [63:0]   PolyA0    = 64'sd361780347;

  localparam logic signed [17:0] M00 = -18'sd9360;
  localparam logic signed [17:0] M01 = 18'sd101531;
  localparam logic signed [17:0] M02 = -18'sd62679;
  localparam logic signed [17:0] M10 = -18'sd21277;
  localparam logic signed [17:0] M11 = 18'sd103440;
  localparam logic signed [17:0] M12 = -18'sd47966;
  localparam logic signed [17:0] M20 = -18'sd44697;
  localparam logic signed [17:0] M21 = 18'sd50511;
  localparam logic signed [17:0] M22 = 18'sd36918;

  // Fate of a sample that needs no arithmetic result.
  typedef struct packed {
    logic zero_in;
    logic degen;
  } flags_t;

  // Saturate a wide signed quotient to the signed 32-bit range.
  function automatic logic signed [QW-1:0] sat32(input logic signed [DivDw-1:0] v);
    logic signed [QW-1:0] r;
    if (v > DivDw'(SatMax)) begin
      r = SatMax;
    end else if (v < DivDw'(SatMin)) begin
      r = SatMin;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/mcct_div.sv
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
module mcct_div #(
  parameter int NumW = mcct_pkg::DivDw,
  parameter int DenW = mcct_pkg::DivDv
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic signed [DenW-1:0] den_i,
  output logic                   valid_o,
  output logic signed [NumW-1:0] quo_o
);

  localparam int RemW = DenW + 1;

  logic [NumW:0]             vld_q;
  logic [NumW-1:0]           quo_q [NumW+1];
  logic [RemW-1:0]           rem_q [NumW+1];
  logic [DenW-1:0]           dmag_q [NumW+1];
  logic                      neg_q [NumW+1];

  // Stage zero holds the magnitudes; each following stage resolves one quotient bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NumW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q[0]  <= num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
    dmag_q[0] <= den_i[DenW-1] ? DenW'(-den_i) : DenW'(den_i);
    rem_q[0]  <= '0;
    neg_q[0]  <= num_i[NumW-1] ^ den_i[DenW-1];
  end

  for (genvar s = 0; s < NumW; s++) begin : g_step
    logic [RemW-1:0] trial;
    logic [RemW-1:0] diff;
    assign trial = {rem_q[s][RemW-2:0], quo_q[s][NumW-1]};
    assign diff  = trial - RemW'(dmag_q[s]);
    always_ff @(posedge clk_i) begin
      dmag_q[s+1] <= dmag_q[s];
      neg_q[s+1]  <= neg_q[s];
      if (!diff[RemW-1]) begin
        rem_q[s+1] <= diff;
        quo_q[s+1] <= {quo_q[s][NumW-2:0], 1'b1};
      end else begin
        rem_q[s+1] <= trial;
        quo_q[s+1] <= {quo_q[s][NumW-2:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[NumW];
  assign quo_o   = neg_q[NumW] ? NumW'(-quo_q[NumW]) : NumW'(quo_q[NumW]);

endmodule

// File: rtl/mccamy_color_temperature.sv
// McCamy correlated color temperature pipeline, from RGB counts to kelvin.
//
// Usage: drive red_count_i, green_count_i and blue_count_i and raise start.
// busy is always low, so a transaction is taken at every rising edge where
// start is high; a new sample may enter in every cycle.
// Each sample gives exactly one result: color_temp_o and degenerate_o are
// shown for one cycle with done_o high, in the order the samples came in.
// Stages in order: the matrix and the sum, a divider pipeline for x and y,
// a register that forms McCamy's numerator and denominator, a second divider
// pipeline for n, and the cubic and the saturation. The long divider chains
// set the latency; throughput is one sample per cycle.
// The receiver cannot stall the block; done_o is a strobe to be caught.
// Reset clears all valid bits, so no result appears from a sample that was
// in flight at reset; data registers are not reset.
// An all-zero sample yields 0; a zero X+Y+Z or a zero 0.1858-y yields 0
// with degenerate_o set.
module mccamy_color_temperature (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] red_count_i,
  input  logic [15:0] green_count_i,
  input  logic [15:0] blue_count_i,
  output logic        done_o,
  output logic [15:0] color_temp_o,
  output logic        degenerate_o
);

  localparam int DivLat = mcct_pkg::DivDw + 1;

  assign busy = 1'b0;

  // Stage 1: nine products.
  logic                          v1_q;
  logic signed [34:0]            p_q [9];
  logic                          z1_q;
  logic signed [17:0]            ch [3];
  assign ch[0] = {2'b00, red_count_i};
  assign ch[1] = {2'b00, green_count_i};
  assign ch[2] = {2'b00, blue_count_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    z1_q   <= (red_count_i == '0) && (green_count_i == '0) && (blue_count_i == '0);
    p_q[0] <= mcct_pkg::M00 * ch[0];
    p_q[1] <= mcct_pkg::M01 * ch[1];
    p_q[2] <= mcct_pkg::M02 * ch[2];
    p_q[3] <= mcct_pkg::M10 * ch[0];
    p_q[4] <= mcct_pkg::M11 * ch[1];
    p_q[5] <= mcct_pkg::M12 * ch[2];
    p_q[6] <= mcct_pkg::M20 * ch[0];
    p_q[7] <= mcct_pkg::M21 * ch[1];
    p_q[8] <= mcct_pkg::M22 * ch[2];
  end

  // Stage 2: tristimulus values.
  logic                                 v2_q, z2_q;
  logic signed [mcct_pkg::TriW-1:0]     tx_q, ty_q, tz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    z2_q <= z1_q;
    tx_q <= mcct_pkg::TriW'(p_q[0]) + mcct_pkg::TriW'(p_q[1]) + mcct_pkg::TriW'(p_q[2]);
    ty_q <= mcct_pkg::TriW'(p_q[3]) + mcct_pkg::TriW'(p_q[4]) + mcct_pkg::TriW'(p_q[5]);
    tz_q <= mcct_pkg::TriW'(p_q[6]) + mcct_pkg::TriW'(p_q[7]) + mcct_pkg::TriW'(p_q[8]);
  end

  // Stage 3: sum and divider operands.
  logic                                 v3_q;
  mcct_pkg::flags_t                     f3_q;
  logic signed [mcct_pkg::DivDw-1:0]    nx_q, ny_q;
  logic signed [mcct_pkg::DivDv-1:0]    s_q;
  logic signed [mcct_pkg::SumW-1:0]     sum;
  assign sum = mcct_pkg::SumW'(tx_q) + mcct_pkg::SumW'(ty_q) + mcct_pkg::SumW'(tz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    f3_q.zero_in <= z2_q;
    f3_q.degen   <= !z2_q && (sum == '0);
    nx_q <= mcct_pkg::DivDw'(tx_q) <<< 16;
    ny_q <= mcct_pkg::DivDw'(ty_q) <<< 16;
    // A zero sum is replaced by one so the divider stays defined; the flag wins.
    s_q  <= (sum == '0) ? mcct_pkg::DivDv'(1) : mcct_pkg::DivDv'(sum);
  end

  logic                              vx, vy;
  logic signed [mcct_pkg::DivDw-1:0] qx, qy;

  mcct_div u_div_x (
    .clk_i, .rst_ni, .valid_i(v3_q), .num_i(nx_q), .den_i(s_q),
    .valid_o(vx), .quo_o(qx)
  );
  mcct_div u_div_y (
    .clk_i, .rst_ni, .valid_i(v3_q), .num_i(ny_q), .den_i(s_q),
    .valid_o(vy), .quo_o(qy)
  );

  // Flags ride alongside the divider.
  mcct_pkg::flags_t f_dl1_q [DivLat];
  always_ff @(posedge clk_i) begin
    f_dl1_q[0] <= f3_q;
    for (int k = 1; k < DivLat; k++) begin
      f_dl1_q[k] <= f_dl1_q[k-1];
    end
  end

  // Stage 4: McCamy numerator and denominator.
  logic                              v4_q;
  mcct_pkg::flags_t                  f4_q;
  logic signed [mcct_pkg::DivDw-1:0] nn_q;
  logic signed [mcct_pkg::DivDv-1:0] nd_q;
  logic signed [mcct_pkg::QW-1:0]    xq, yq;
  logic signed [mcct_pkg::QW:0]      den;
  assign xq  = mcct_pkg::sat32(qx);
  assign yq  = mcct_pkg::sat32(qy);
  assign den = (mcct_pkg::QW+1)'(mcct_pkg::YEpiQ16) - (mcct_pkg::QW+1)'(yq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= vx && vy;
    end
  end
  always_ff @(posedge clk_i) begin
    f4_q.zero_in <= f_dl1_q[DivLat-1].zero_in;
    f4_q.degen   <= f_dl1_q[DivLat-1].degen
                    || (!f_dl1_q[DivLat-1].zero_in && (den == '0));
    nn_q <= mcct_pkg::DivDw'((mcct_pkg::QW+1)'(xq)
                             - (mcct_pkg::QW+1)'(mcct_pkg::XWhiteQ16)) <<< 16;
    nd_q <= (den == '0) ? mcct_pkg::DivDv'(1) : mcct_pkg::DivDv'(den);
  end

  logic                              vn;
  logic signed [mcct_pkg::DivDw-1:0] qn;
  mcct_div u_div_n (
    .clk_i, .rst_ni, .valid_i(v4_q), .num_i(nn_q), .den_i(nd_q),
    .valid_o(vn), .quo_o(qn)
  );

  mcct_pkg::flags_t f_dl2_q [DivLat];
  always_ff @(posedge clk_i) begin
    f_dl2_q[0] <= f4_q;
    for (int k = 1; k < DivLat; k++) begin
      f_dl2_q[k] <= f_dl2_q[k-1];
    end
  end

  // Cubic stages: clamp, square, cube, terms, add, scale and saturate.
  logic signed [mcct_pkg::QW-1:0] nsat, ncl;
  assign nsat = mcct_pkg::sat32(qn);
  assign ncl  = (nsat < mcct_pkg::NMinQ16) ? mcct_pkg::NMinQ16
              : (nsat > mcct_pkg::NMaxQ16) ? mcct_pkg::NMaxQ16 : nsat;

  logic [6:0]                     vc_q;
  mcct_pkg::flags_t               fc_q [7];
  logic signed [24:0]             n5_q, n6_q, n7_q;
  logic signed [49:0]             sq_q;
  logic signed [33:0]             n2_q;
  logic signed [58:0]             cb_q;
  logic signed [63:0]             t3_q, t2_q, t1_q, acc_q;
  logic signed [47:0]             cct_q;
  logic [15:0]                    ct_q;
  logic signed [33:0]             n2c;
  logic signed [33:0]             n3c;

  assign n2c  = 34'(sq_q / 50'sd65536);
  assign n3c  = 34'(cb_q / 59'sd65536);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= '0;
    end else begin
      vc_q <= {vc_q[5:0], vn};
    end
  end

  always_ff @(posedge clk_i) begin
    fc_q[0] <= f_dl2_q[DivLat-1];
    for (int k = 1; k < 7; k++) begin
      fc_q[k] <= fc_q[k-1];
    end
    n5_q  <= 25'(ncl);
    sq_q  <= 50'(n5_q) * 50'(n5_q);
    n6_q  <= n5_q;
    n2_q  <= n2c;
    n7_q  <= n6_q;
    cb_q  <= 59'(n2c) * 59'(n6_q);
    // The linear term is formed from the delayed copy n7_q so it meets the other terms.
    t1_q  <= 64'(57'(mcct_pkg::PolyA1) * 57'(n7_q) / 57'sd65536);
    t3_q  <= 64'(mcct_pkg::PolyA3) * 64'(n3c);
    t2_q  <= 64'(mcct_pkg::PolyA2) * 64'(n2_q);
    acc_q <= t3_q + t2_q + t1_q + mcct_pkg::PolyA0;
    cct_q <= 48'(acc_q / 64'sd65536);
    if (cct_q < 0) begin
      ct_q <= '0;
    end else if (cct_q > 48'sd65535) begin
      ct_q <= 16'hffff;
    end else begin
      ct_q <= cct_q[15:0];
    end
  end

  assign done_o       = vc_q[6];
  assign color_temp_o = (fc_q[6].zero_in || fc_q[6].degen) ? '0 : ct_q;
  assign degenerate_o = fc_q[6].degen;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |-> color_temp_o == '0)
    else $error("degenerate result with nonzero temperature");
  a_div_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vx == vy)
    else $error("x and y dividers out of step");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vn |-> ##7 done_o)
    else $error("cubic pipeline lost a transaction");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(fc_q[6].zero_in && fc_q[6].degen))
    else $error("zero sample marked degenerate");

endmodule

// File: tb/mccamy_color_temperature_tb.sv
// Self-checking testbench for the McCamy color temperature pipeline.
module mccamy_color_temperature_tb;

  localparam int Latency = 125;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        known;
    logic [15:0] temp;
    logic        degen;
  } sample_row_t;

  typedef struct {
    logic [15:0] temp;
    logic        degen;
  } cct_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] red_count_i = '0;
  logic [15:0] green_count_i = '0;
  logic [15:0] blue_count_i = '0;
  logic        done_o;
  logic [15:0] color_temp_o;
  logic        degenerate_o;

  cct_t pending_cct[$];
  int   errors = 0;
  int   idle_pct = 0;

  mccamy_color_temperature dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .red_count_i  (red_count_i),
    .green_count_i(green_count_i),
    .blue_count_i (blue_count_i),
    .done_o       (done_o),
    .color_temp_o (color_temp_o),
    .degenerate_o (degenerate_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint clip_s32(longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic cct_t mccamy_cct(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    longint mat[3][3] = '{'{-9360, 101531, -62679},
                          '{-21277, 103440, -47966},
                          '{-44697, 50511, 36918}};
    longint rgb[3];
    longint xyz[3];
    longint total, xq, yq, den, n, n2, n3, acc, k;
    cct_t res;
    res.temp = '0;
    res.degen = 1'b0;
    rgb[0] = longint'(r);
    rgb[1] = longint'(g);
    rgb[2] = longint'(b);
    if (r == 0 && g == 0 && b == 0) begin
      return res;
    end
    for (int i = 0; i < 3; i++) begin
      xyz[i] = 0;
      for (int j = 0; j < 3; j++) begin
        xyz[i] += mat[i][j] * rgb[j];
      end
    end
    total = xyz[0] + xyz[1] + xyz[2];
    if (total == 0) begin
      res.degen = 1'b1;
      return res;
    end
    xq = clip_s32((xyz[0] * 65536) / total);
    yq = clip_s32((xyz[1] * 65536) / total);
    den = 12177 - yq;
    if (den == 0) begin
      res.degen = 1'b1;
      return res;
    end
    n = clip_s32(((xq - 21758) * 65536) / den);
    if (n < -16 * 65536) begin
      n = -16 * 65536;
    end
    if (n > 8 * 65536) begin
      n = 8 * 65536;
    end
    n2 = (n * n) / 65536;
    n3 = (n2 * n) / 65536;
    acc = 449 * n3 + 3525 * n2 + (64'sd447171789 * n) / 65536 + 64'sd361780347;
    k = acc / 65536;
    if (k < 0) begin
      k = 0;
    end
    if (k > 65535) begin
      k = 65535;
    end
    res.temp = k[15:0];
    return res;
  endfunction

  // One transaction; the gap after it is drawn from the current idle rate.
  task automatic send_sample(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    red_count_i <= r;
    green_count_i <= g;
    blue_count_i <= b;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    pending_cct.push_back(mccamy_cct(r, g, b));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    cct_t want;
    if (rst_ni && done_o) begin
      if (pending_cct.size() == 0) begin
        $error("unexpected result: color_temp %0d degenerate %0b", color_temp_o, degenerate_o);
        errors++;
      end else begin
        want = pending_cct.pop_front();
        if (color_temp_o !== want.temp) begin
          $error("color_temp: expected %0d, got %0d", want.temp, color_temp_o);
          errors++;
        end
        if (degenerate_o !== want.degen) begin
          $error("degenerate: expected %0b, got %0b", want.degen, degenerate_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    sample_row_t rows[$];
    int pcts[4];
    int wait_cycles;
    logic [15:0] r, g, b;
    cct_t chk;

    pcts = '{0, 74, 16, 0};
    rows = '{
      '{16'h0000, 16'h0000, 16'h0000, 1'b1, 16'd0, 1'b0},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0, 1'b0},
      '{16'hFFFF, 16'h0000, 16'h0000, 1'b0, 16'd0, 1'b0},
      '{16'h0000, 16'hFFFF, 16'h0000, 1'b0, 16'd0, 1'b0},
      '{16'h0000, 16'h0000, 16'hFFFF, 1'b0, 16'd0, 1'b0},
      '{16'h0001, 16'h0000, 16'h0000, 1'b0, 16'd0, 1'b0},
      '{16'h0000, 16'h0001, 16'h0000, 1'b0, 16'd0, 1'b0},
      '{16'h0000, 16'h0000, 16'h0001, 1'b0, 16'd0, 1'b0},
      '{16'h0001, 16'h0001, 16'h0001, 1'b0, 16'd0, 1'b0},
      '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 16'd0, 1'b0},
      '{16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0, 1'b0},
      '{16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 16'd0, 1'b0},
      '{16'd1000, 16'd1200, 16'd900, 1'b0, 16'd0, 1'b0},
      '{16'd3000, 16'd2000, 16'd1000, 1'b0, 16'd0, 1'b0},
      '{16'd500, 16'd1500, 16'd2500, 1'b0, 16'd0, 1'b0},
      '{16'h8000, 16'h4000, 16'h2000, 1'b0, 16'd0, 1'b0},
      '{16'h5555, 16'hAAAA, 16'h5555, 1'b0, 16'd0, 1'b0},
      '{16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 16'd0, 1'b0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].known) begin
        chk = mccamy_cct(rows[i].red, rows[i].green, rows[i].blue);
        if (chk.temp !== rows[i].temp || chk.degen !== rows[i].degen) begin
          $error("table row %0d disagrees with its typed result", i);
          errors++;
        end
      end
      send_sample(rows[i].red, rows[i].green, rows[i].blue);
    end

    for (int i = 0; i < 650; i++) begin
      idle_pct = pcts[(i / 80) % 4];
      case ($urandom_range(3))
        0: begin
          r = 16'($urandom);
          g = 16'($urandom);
          b = 16'($urandom);
        end
        1: begin
          // Small counts reach the rounding corners of the divisions.
          r = 16'($urandom_range(0, 8));
          g = 16'($urandom_range(0, 8));
          b = 16'($urandom_range(0, 8));
        end
        default: begin
          // Roughly balanced light lands the cubic inside its usable range.
          g = 16'($urandom_range(100, 60000));
          r = 16'((g * $urandom_range(50, 150)) / 100);
          b = 16'((g * $urandom_range(30, 150)) / 100);
        end
      endcase
      send_sample(r, g, b);
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (pending_cct.size() != 0 && wait_cycles < 10 * Latency) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (Latency + 5) @(posedge clk_i);
    if (errors == 0 && pending_cct.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (pending_cct.size() != 0) begin
        $error("%0d results never arrived", pending_cct.size());
      end
      $display("FAILURE");
    end
    $finish;
  end

endmodule
